// ===== rtl/core/segmenting_transmit_task_queue_assert.svh =====
// Assertion macros shared by the transmit task queue RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SEGMENTING_TRANSMIT_TASK_QUEUE_ASSERT_SVH
`define SEGMENTING_TRANSMIT_TASK_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STTQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("transmit task queue: check failed");

// Next-cycle implication, checked outside reset.
`define STTQ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("transmit task queue: check failed");

`endif

// ===== rtl/core/sttq_pkg.sv =====
// Types, codes and defaults of the segmenting transmit task queue.
// No dependencies.
package sttq_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam logic [7:0] MAX_SEGMENT_RST = 8'd40;

    // Configuration register indexes
    localparam logic CFG_LINK_OPEN   = 1'b0;
    localparam logic CFG_MAX_SEGMENT = 1'b1;

    typedef enum logic [1:0] {
        SLOT_IDLE    = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_SENDING = 2'd2
    } t_slot_state;

    typedef enum logic [1:0] {
        REG_NONE = 2'd0,
        REG_OK   = 2'd1,
        REG_FULL = 2'd2
    } t_reg_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG_SCAN,
        ST_SEND_SCAN,
        ST_SEND_EXEC,
        ST_FINISH
    } t_fsm;

    // One slot entry as held in the slot memory
    typedef struct packed {
        logic [31:0] address;
        logic [14:0] length;
        logic [14:0] sent;
        logic [7:0]  unit;
        logic        notify;
        logic [31:0] tag;
    } t_slot;

    typedef struct packed {
        logic        operation;
        logic [31:0] address;
        logic [14:0] length;
        logic        notify;
        logic [31:0] tag;
        logic        link_can_accept;
    } t_request;

    typedef struct packed {
        t_reg_status reg_status;
        logic        seg_valid;
        logic [31:0] seg_address;
        logic [8:0]  seg_length;
        logic        seg_first;
        logic        seg_last;
        logic        task_done;
        logic [31:0] done_tag;
    } t_result;

endpackage

// ===== rtl/core/sttq_slot_mem.sv =====
// Slot memory: one write port, one read port with registered read data.
// Depends on sttq_pkg for the slot entry type.
module sttq_slot_mem #(
    parameter int SLOT_COUNT = sttq_pkg::SLOT_COUNT_DEF,
    localparam int SLOT_AW = $clog2(SLOT_COUNT)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [SLOT_AW-1:0]   i_wr_addr,
    input  sttq_pkg::t_slot      i_wr_data,
    input  logic                 i_rd_en,
    input  logic [SLOT_AW-1:0]   i_rd_addr,
    output sttq_pkg::t_slot      o_rd_data
);

    sttq_pkg::t_slot r_mem [SLOT_COUNT];
    sttq_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/segmenting_transmit_task_queue.sv =====
// The registration search and the send search together visit at most SLOT_COUNT+1 slots,
// one per cycle, then one slot memory read and one result hand-off. One request at a time;
// the block takes no new request until the last result is handed off, and a finished
// result may wait on a stalled output.
// Reset (synchronous, i_rst_n low): all slots idle, service position 0, link closed,
// max segment 40, no result pending. Slot memory needs no clearing.
module segmenting_transmit_task_queue #(
    parameter int SLOT_COUNT = sttq_pkg::SLOT_COUNT_DEF,
    localparam int SLOT_AW = $clog2(SLOT_COUNT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [31:0]        i_buffer_address,
    input  logic [14:0]        i_buffer_length,
    input  logic               i_notify_on_done,
    input  logic signed [31:0] i_completion_tag,
    input  logic               i_link_can_accept,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_register_status,
    output logic               o_segment_valid,
    output logic [31:0]        o_segment_address,
    output logic [8:0]         o_segment_length,
    output logic               o_segment_first,
    output logic               o_segment_last,
    output logic               o_task_done,
    output logic signed [31:0] o_done_tag,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    localparam logic [SLOT_AW-1:0] LAST = SLOT_AW'(SLOT_COUNT - 1);

    function automatic logic [SLOT_AW-1:0] f_next(input logic [SLOT_AW-1:0] s);
        return (s == LAST) ? '0 : s + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sttq_pkg::t_fsm        r_state, n_state;
    sttq_pkg::t_slot_state r_slot_state [SLOT_COUNT];
    sttq_pkg::t_slot_state n_slot_state [SLOT_COUNT];
    logic [SLOT_AW-1:0]    r_pos, n_pos;      // service position, also the send scan pointer
    logic [SLOT_AW-1:0]    r_ptr, n_ptr;      // registration scan pointer
    logic [SLOT_AW-1:0]    r_cnt, n_cnt;      // slots visited in the current scan
    sttq_pkg::t_request    r_req, n_req;
    sttq_pkg::t_result     r_res, n_res;      // result under construction
    sttq_pkg::t_result     r_out, n_out;      // result offered downstream
    logic                  r_out_valid, n_out_valid;
    logic                  r_link_open;
    logic [7:0]            r_max_segment;

    // slot memory port
    logic               mem_wr_en;
    logic [SLOT_AW-1:0] mem_wr_addr;
    sttq_pkg::t_slot    mem_wr_data;
    logic               mem_rd_en;
    sttq_pkg::t_slot    mem_rd_data;

    sttq_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Segment arithmetic on the slot read back from memory.
    // A ready slot fixes its unit now; a sending slot reuses the stored one.
    // ------------------------------------------------------------------
    logic [14:0] seg_left;
    logic [7:0]  seg_limit;
    logic [7:0]  seg_unit;
    logic [15:0] seg_sum;
    logic        seg_fin;
    logic        seg_was_ready;

    assign seg_was_ready = (r_slot_state[r_pos] == sttq_pkg::SLOT_READY);
    assign seg_left      = mem_rd_data.length - mem_rd_data.sent;
    assign seg_limit     = (r_max_segment == 8'd0) ? 8'd1 : r_max_segment;
    assign seg_unit      = !seg_was_ready ? mem_rd_data.unit
                         : (seg_left > {7'd0, seg_limit}) ? seg_limit : seg_left[7:0];
    assign seg_sum       = {1'b0, mem_rd_data.sent} + {8'd0, seg_unit};
    assign seg_fin       = seg_sum >= {1'b0, mem_rd_data.length};

    // ------------------------------------------------------------------
    // Configuration: always ready; the user must write it only while the queue is idle (not enforced).
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_open   <= 1'b0;
            r_max_segment <= sttq_pkg::MAX_SEGMENT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sttq_pkg::CFG_LINK_OPEN:   r_link_open   <= i_cfg_data[0];
                sttq_pkg::CFG_MAX_SEGMENT: r_max_segment <= i_cfg_data;
                default:                   r_link_open   <= r_link_open;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, memory port and result assembly
    // ------------------------------------------------------------------
    assign o_stall = (r_state != sttq_pkg::ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_slot_state = r_slot_state;
        n_pos        = r_pos;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_req        = r_req;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_stall;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_ptr;
        mem_wr_data  = mem_rd_data;
        mem_rd_en    = 1'b0;

        unique case (r_state)
            sttq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    // Latch the request and clear the result under construction.
                    n_req.operation       = i_operation;
                    n_req.address         = i_buffer_address;
                    n_req.length          = i_buffer_length;
                    n_req.notify          = i_notify_on_done;
                    n_req.tag             = i_completion_tag;
                    n_req.link_can_accept = i_link_can_accept;
                    n_res                 = '0;
                    n_cnt                 = '0;
                    if (i_operation == 1'b0) begin
                        // registration searches from the slot after the service position
                        n_ptr   = f_next(r_pos);
                        n_state = sttq_pkg::ST_REG_SCAN;
                    end else if (r_link_open) begin
                        n_state = sttq_pkg::ST_SEND_SCAN;
                    end else begin
                        n_state = sttq_pkg::ST_FINISH;
                    end
                end
            end

            sttq_pkg::ST_REG_SCAN: begin
                if (r_slot_state[r_ptr] == sttq_pkg::SLOT_IDLE) begin
                    // Take the free slot: write its entry and mark it ready.
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = r_ptr;
                    mem_wr_data.address = r_req.address;
                    mem_wr_data.length = r_req.length;
                    mem_wr_data.sent   = '0;
                    mem_wr_data.unit   = '0;
                    mem_wr_data.notify = r_req.notify;
                    mem_wr_data.tag    = r_req.tag;
                    n_slot_state[r_ptr] = sttq_pkg::SLOT_READY;
                    n_res.reg_status   = sttq_pkg::REG_OK;
                    n_cnt              = '0;
                    n_state            = r_link_open ? sttq_pkg::ST_SEND_SCAN
                                                     : sttq_pkg::ST_FINISH;
                end else if (r_cnt == LAST) begin
                    // queue full: no send attempt in this request
                    n_res.reg_status = sttq_pkg::REG_FULL;
                    n_state          = sttq_pkg::ST_FINISH;
                end else begin
                    n_ptr = f_next(r_ptr);
                    n_cnt = r_cnt + 1'b1;
                end
            end

            sttq_pkg::ST_SEND_SCAN: begin
                if (r_slot_state[r_pos] != sttq_pkg::SLOT_IDLE) begin
                    // Fetch the slot; the entry is back next cycle.
                    mem_rd_en = 1'b1;
                    n_state   = sttq_pkg::ST_SEND_EXEC;
                end else begin
                    // Advance; after a full lap the position is back where it began.
                    n_pos = f_next(r_pos);
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        n_state = sttq_pkg::ST_FINISH;
                    end
                end
            end

            sttq_pkg::ST_SEND_EXEC: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_pos;
                n_state     = sttq_pkg::ST_FINISH;
                if (!r_req.link_can_accept) begin
                    // Link refuses: hold the fixed unit and keep the slot sending.
                    mem_wr_data.unit    = seg_unit;
                    n_slot_state[r_pos] = sttq_pkg::SLOT_SENDING;
                end else begin
                    n_res.seg_valid   = 1'b1;
                    n_res.seg_address = mem_rd_data.address + 32'(mem_rd_data.sent) - 32'd1;
                    n_res.seg_length  = {1'b0, seg_unit} + 9'd1;
                    n_res.seg_first   = (mem_rd_data.sent == 15'd0);
                    n_res.seg_last    = seg_fin;
                    mem_wr_data.sent  = seg_sum[14:0];
                    mem_wr_data.unit  = '0;
                    if (seg_fin) begin
                        // Task finished: free the slot and move the position on.
                        n_slot_state[r_pos] = sttq_pkg::SLOT_IDLE;
                        n_pos               = f_next(r_pos);
                        if (mem_rd_data.notify) begin
                            n_res.task_done = 1'b1;
                            n_res.done_tag  = mem_rd_data.tag;
                        end
                    end else begin
                        n_slot_state[r_pos] = sttq_pkg::SLOT_READY;
                    end
                end
            end

            sttq_pkg::ST_FINISH: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = sttq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sttq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sttq_pkg::ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_slot_state[k] <= sttq_pkg::SLOT_IDLE;
            end
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
            r_slot_state <= n_slot_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_cnt <= n_cnt;
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign o_valid           = r_out_valid;
    assign o_register_status = r_out.reg_status;
    assign o_segment_valid   = r_out.seg_valid;
    assign o_segment_address = r_out.seg_address;
    assign o_segment_length  = r_out.seg_length;
    assign o_segment_first   = r_out.seg_first;
    assign o_segment_last    = r_out.seg_last;
    assign o_task_done       = r_out.task_done;
    assign o_done_tag        = $signed(r_out.done_tag);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`include "segmenting_transmit_task_queue_assert.svh"

    `STTQ_ASSERT_IMP(a_pos_in_range, 1'b1, r_pos <= LAST)
    `STTQ_ASSERT_IMP(a_full_no_send, o_valid && o_register_status == sttq_pkg::REG_FULL, !o_segment_valid)
    `STTQ_ASSERT_IMP(a_done_is_last, o_valid && o_task_done, o_segment_valid && o_segment_last)
    `STTQ_ASSERT_IMP(a_mem_one_port, mem_wr_en, !mem_rd_en)
    `STTQ_ASSERT_NXT(a_read_then_exec, mem_rd_en, r_state == sttq_pkg::ST_SEND_EXEC)

endmodule

// ===== verif/segmenting_transmit_task_queue_checker.sv =====
// Checker for the segmenting transmit task queue: watches the request, result and
// register channels, predicts each result and compares it field by field.
// Depends on sttq_pkg for slot states, status codes and the request/result structs.
`timescale 1ns / 100ps

module segmenting_transmit_task_queue_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic        i_operation,
    input  logic [31:0] i_buffer_address,
    input  logic [14:0] i_buffer_length,
    input  logic        i_notify_on_done,
    input  logic [31:0] i_completion_tag,
    input  logic        i_link_can_accept,
    input  logic        i_out_valid,
    input  logic        i_stall,
    input  logic [1:0]  i_register_status,
    input  logic        i_segment_valid,
    input  logic [31:0] i_segment_address,
    input  logic [8:0]  i_segment_length,
    input  logic        i_segment_first,
    input  logic        i_segment_last,
    input  logic        i_task_done,
    input  logic [31:0] i_done_tag,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_busy_slots,
    output int          o_segment_count,
    output int          o_done_count,
    output int          o_full_count
);

    localparam int NSLOT = sttq_pkg::SLOT_COUNT_DEF;

    sttq_pkg::t_slot_state slot_st [NSLOT];
    logic [31:0] slot_addr   [NSLOT];
    logic [14:0] slot_len    [NSLOT];
    logic [14:0] slot_sent   [NSLOT];
    logic [7:0]  slot_unit   [NSLOT];
    logic        slot_notify [NSLOT];
    logic [31:0] slot_tag    [NSLOT];
    int          position;
    logic        link_open;
    logic [7:0]  seg_max;

    sttq_pkg::t_result expected_results [$];
    int                fails;

    function automatic int next_slot(input int s);
        return (s + 1 >= NSLOT) ? 0 : s + 1;
    endfunction

    // Advance the slot table by one request and return the result it produces.
    function automatic sttq_pkg::t_result step_queue(input sttq_pkg::t_request rq);
        sttq_pkg::t_result res;
        int      c;
        int      n;
        int      p;
        int      left;
        int      lim;
        bit      placed;
        bit      finished;
        res = '0;
        res.reg_status = sttq_pkg::REG_NONE;
        if (rq.operation == 1'b0) begin
            placed = 1'b0;
            c = next_slot(position);
            for (n = 0; n < NSLOT && !placed; n++) begin
                if (slot_st[c] == sttq_pkg::SLOT_IDLE) begin
                    slot_addr[c]   = rq.address;
                    slot_len[c]    = rq.length;
                    slot_sent[c]   = '0;
                    slot_unit[c]   = '0;
                    slot_notify[c] = rq.notify;
                    slot_tag[c]    = rq.tag;
                    slot_st[c]     = sttq_pkg::SLOT_READY;
                    placed = 1'b1;
                end else begin
                    c = next_slot(c);
                end
            end
            if (!placed) begin
                res.reg_status = sttq_pkg::REG_FULL;
                return res;
            end
            res.reg_status = sttq_pkg::REG_OK;
        end
        if (!link_open)
            return res;
        // Scan from the service position for a slot with data to go.
        for (n = 0; n < NSLOT; n++) begin
            p = position;
            if (slot_st[p] == sttq_pkg::SLOT_READY) begin
                left = int'(slot_len[p]) - int'(slot_sent[p]);
                lim  = (seg_max == 8'd0) ? 1 : int'(seg_max);
                slot_unit[p] = 8'((left > lim) ? lim : left);
                slot_st[p] = sttq_pkg::SLOT_SENDING;
            end
            if (slot_st[p] == sttq_pkg::SLOT_SENDING) begin
                // A refused segment keeps its unit for the next offer.
                if (!rq.link_can_accept)
                    return res;
                finished = int'(slot_sent[p]) + int'(slot_unit[p]) >= int'(slot_len[p]);
                res.seg_valid   = 1'b1;
                res.seg_address = slot_addr[p] + 32'(slot_sent[p]) - 32'd1;
                res.seg_length  = 9'(slot_unit[p]) + 9'd1;
                res.seg_first   = (slot_sent[p] == 15'd0);
                res.seg_last    = finished;
                slot_sent[p] = slot_sent[p] + 15'(slot_unit[p]);
                if (finished) begin
                    if (slot_notify[p]) begin
                        res.task_done = 1'b1;
                        res.done_tag  = slot_tag[p];
                    end
                    slot_st[p] = sttq_pkg::SLOT_IDLE;
                    position = next_slot(p);
                end else begin
                    slot_st[p]   = sttq_pkg::SLOT_READY;
                    slot_unit[p] = '0;
                end
                return res;
            end
            position = next_slot(p);
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s differs: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        sttq_pkg::t_result  got;
        sttq_pkg::t_result  want;
        sttq_pkg::t_request req;
        int                 busy;
        if (!i_rst_n) begin
            for (int k = 0; k < NSLOT; k++) begin
                slot_st[k]     = sttq_pkg::SLOT_IDLE;
                slot_addr[k]   = '0;
                slot_len[k]    = '0;
                slot_sent[k]   = '0;
                slot_unit[k]   = '0;
                slot_notify[k] = 1'b0;
                slot_tag[k]    = '0;
            end
            position  = 0;
            link_open = 1'b0;
            seg_max   = sttq_pkg::MAX_SEGMENT_RST;
            expected_results.delete();
            fails = 0;
            o_segment_count <= 0;
            o_done_count    <= 0;
            o_full_count    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == sttq_pkg::CFG_LINK_OPEN)
                    link_open = i_cfg_data[0];
                else
                    seg_max = i_cfg_data;
            end
            if (i_out_valid && !i_stall) begin
                got.reg_status  = sttq_pkg::t_reg_status'(i_register_status);
                got.seg_valid   = i_segment_valid;
                got.seg_address = i_segment_address;
                got.seg_length  = i_segment_length;
                got.seg_first   = i_segment_first;
                got.seg_last    = i_segment_last;
                got.task_done   = i_task_done;
                got.done_tag    = i_done_tag;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("register_status", want.reg_status, got.reg_status);
                    check_field("segment_valid", want.seg_valid, got.seg_valid);
                    check_field("segment_address", want.seg_address, got.seg_address);
                    check_field("segment_length", want.seg_length, got.seg_length);
                    check_field("segment_first", want.seg_first, got.seg_first);
                    check_field("segment_last", want.seg_last, got.seg_last);
                    check_field("task_done", want.task_done, got.task_done);
                    check_field("done_tag", want.done_tag, got.done_tag);
                end
                o_segment_count <= o_segment_count + int'(got.seg_valid);
                o_done_count    <= o_done_count + int'(got.task_done);
                o_full_count    <= o_full_count + int'(got.reg_status == sttq_pkg::REG_FULL);
            end
            if (i_valid && !i_in_stall) begin
                req = {i_operation, i_buffer_address, i_buffer_length, i_notify_on_done,
                       i_completion_tag, i_link_can_accept};
                expected_results.push_back(step_queue(req));
            end
        end
        busy = 0;
        for (int k = 0; k < NSLOT; k++)
            busy += int'(slot_st[k] != sttq_pkg::SLOT_IDLE);
        o_busy_slots <= busy;
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/segmenting_transmit_task_queue_test.sv =====
// Top of the transmit task queue testbench: clock, reset, request and register stimulus,
// and the verdict. Depends on sttq_pkg, the block and segmenting_transmit_task_queue_checker.
`timescale 1ns / 100ps

module segmenting_transmit_task_queue_test;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_SEND     = 1'b1;
    localparam int   NPHASE      = 8;
    localparam int   PHASE_ITEMS = 72;
    // Watchdog limit on the run length, well above the slowest correct run.
    localparam int   RUN_LIMIT   = 1000000;
    localparam int   TAIL_CYCLES = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [31:0] i_buffer_address = '0;
    logic [14:0] i_buffer_length = '0;
    logic        i_notify_on_done = 1'b0;
    logic [31:0] i_completion_tag = '0;
    logic        i_link_can_accept = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_register_status;
    logic        o_segment_valid;
    logic [31:0] o_segment_address;
    logic [8:0]  o_segment_length;
    logic        o_segment_first;
    logic        o_segment_last;
    logic        o_task_done;
    logic [31:0] o_done_tag;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = sttq_pkg::CFG_LINK_OPEN;
    logic [7:0]  i_cfg_data = '0;

    int fail_count;
    int pending;
    int busy_slots;
    int segment_count;
    int done_count;
    int full_count;

    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int requests_sent = 0;
    int settings_written = 0;

    // Per-phase link state, segment limit (-1 picks one at random), idling, stalling and request mix.
    int phase_link  [NPHASE] = '{1, 1, 1, 1, 0, 1, 1, 1};
    int phase_max   [NPHASE] = '{40, 255, 1, 0, -1, 200, 3, -1};
    int phase_idle  [NPHASE] = '{0, 78, 0, 15, 0, 78, 0, 15};
    int phase_stall [NPHASE] = '{0, 0, 78, 15, 0, 0, 78, 15};
    int phase_reg   [NPHASE] = '{35, 35, 40, 40, 60, 30, 35, 50};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    // Receiver side: stall at random, at the rate of the current phase.
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < stall_pct);

    segmenting_transmit_task_queue i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_buffer_address  (i_buffer_address),
        .i_buffer_length   (i_buffer_length),
        .i_notify_on_done  (i_notify_on_done),
        .i_completion_tag  (i_completion_tag),
        .i_link_can_accept (i_link_can_accept),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_register_status (o_register_status),
        .o_segment_valid   (o_segment_valid),
        .o_segment_address (o_segment_address),
        .o_segment_length  (o_segment_length),
        .o_segment_first   (o_segment_first),
        .o_segment_last    (o_segment_last),
        .o_task_done       (o_task_done),
        .o_done_tag        (o_done_tag),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    segmenting_transmit_task_queue_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_in_stall        (o_stall),
        .i_operation       (i_operation),
        .i_buffer_address  (i_buffer_address),
        .i_buffer_length   (i_buffer_length),
        .i_notify_on_done  (i_notify_on_done),
        .i_completion_tag  (i_completion_tag),
        .i_link_can_accept (i_link_can_accept),
        .i_out_valid       (o_valid),
        .i_stall           (i_stall),
        .i_register_status (o_register_status),
        .i_segment_valid   (o_segment_valid),
        .i_segment_address (o_segment_address),
        .i_segment_length  (o_segment_length),
        .i_segment_first   (o_segment_first),
        .i_segment_last    (o_segment_last),
        .i_task_done       (o_task_done),
        .i_done_tag        (o_done_tag),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_busy_slots      (busy_slots),
        .o_segment_count   (segment_count),
        .o_done_count      (done_count),
        .o_full_count      (full_count)
    );

    // Offer one request and hold it until accepted. Keep valid high on return so a
    // following request goes out back to back; drop it only when idling.
    task automatic push_request(input logic op, input logic [31:0] addr,
                                input logic [14:0] len, input logic notify,
                                input logic [31:0] tag, input logic accept);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_operation       <= op;
        i_buffer_address  <= addr;
        i_buffer_length   <= len;
        i_notify_on_done  <= notify;
        i_completion_tag  <= tag;
        i_link_can_accept <= accept;
        i_valid           <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    // Drop valid in the accepting step, then hold until every result is back.
    // The first edge lets the checker's pending count catch up.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_written++;
        @(posedge i_clk);
    endtask

    // Watchdog: end the run if the block hangs or results go missing.
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("segmenting_transmit_task_queue: mismatch");
        $finish;
    end

    initial begin
        int          lens [10] = '{0, 1, 40, 41, 255, 256, 300, 2, 80, 5};
        int          eff_max;
        int          len_cap;
        logic [7:0]  max_val;
        logic [14:0] len;
        logic        op;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Link is closed out of reset: the send request does nothing
        // and registrations only fill slots, until the eleventh finds the table full.
        push_request(OP_SEND, '0, '0, 1'b0, '0, 1'b1);
        for (int k = 0; k < 10; k++)
            push_request(OP_REGISTER,
                         (k == 0) ? 32'h0000_0000 : (k == 1) ? 32'hFFFF_FFFF : $urandom,
                         15'(lens[k]), (k < 2) ? 1'b1 : 1'(k % 2),
                         (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7FFF_FFFF : $urandom,
                         1'($urandom_range(1)));
        push_request(OP_REGISTER, $urandom, 15'd10, 1'b1, $urandom, 1'b1);
        wait_idle();

        // Open the link with the widest segments, then let the link refuse: the
        // chosen slot fixes its unit, which must survive the drop to one byte.
        write_reg(sttq_pkg::CFG_LINK_OPEN, 8'd1);
        write_reg(sttq_pkg::CFG_MAX_SEGMENT, 8'd255);
        push_request(OP_SEND, $urandom, 15'd0, 1'b0, $urandom, 1'b0);
        wait_idle();
        write_reg(sttq_pkg::CFG_MAX_SEGMENT, 8'd1);
        push_request(OP_SEND, $urandom, 15'd0, 1'b0, $urandom, 1'b1);
        wait_idle();
        write_reg(sttq_pkg::CFG_MAX_SEGMENT, 8'd40);
        for (int k = 0; k < 4; k++)
            push_request(OP_SEND, $urandom, 15'($urandom), 1'($urandom_range(1)), $urandom,
                         1'b1);
        wait_idle();

        // Random phases: each sets the link and segment limit while idle, then runs
        // mostly small tasks of at most three segments under the chosen limit.
        for (int ph = 0; ph < NPHASE; ph++) begin
            max_val = (phase_max[ph] < 0) ? 8'($urandom_range(255)) : 8'(phase_max[ph]);
            write_reg(sttq_pkg::CFG_LINK_OPEN, 8'(phase_link[ph]));
            write_reg(sttq_pkg::CFG_MAX_SEGMENT, max_val);
            send_idle_pct = phase_idle[ph];
            stall_pct     = phase_stall[ph];
            eff_max = (max_val == 8'd0) ? 1 : int'(max_val);
            len_cap = (phase_link[ph] == 0) ? 60 : 3 * eff_max;

            // With the widest segments, push one task of the largest length through.
            if (phase_link[ph] != 0 && eff_max == 255)
                push_request(OP_REGISTER, $urandom, 15'h7FFF, 1'b1, $urandom, 1'b1);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once, hold the sender until everything outstanding has come back.
                if (ph == 3 && n == PHASE_ITEMS / 2)
                    wait_idle();
                op  = ($urandom_range(99) < phase_reg[ph]) ? OP_REGISTER : OP_SEND;
                len = 15'($urandom_range(len_cap));
                push_request(op, $urandom, len, 1'($urandom_range(1)), $urandom,
                             1'($urandom_range(99) < 85));
            end
            wait_idle();

            // Drain leftover tasks before the limit changes, so none crawls along
            // at one byte per segment.
            if (phase_link[ph] != 0) begin
                while (busy_slots != 0)
                    push_request(OP_SEND, $urandom, 15'($urandom), 1'($urandom_range(1)),
                                 $urandom, 1'b1);
                wait_idle();
            end
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests under %0d register writes, link open and closed,",
                 requests_sent, settings_written);
        $display("segment limits 0 to 255: %0d segments, %0d completions, %0d full replies.",
                 segment_count, done_count, full_count);
        if (fail_count == 0) begin
            $display("segmenting_transmit_task_queue: match");
        end else begin
            $display("segmenting_transmit_task_queue: mismatch");
        end
        $finish;
    end

endmodule
